/* hw/rtl/jps_pkg.sv */
package jps_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_SOLVE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] REG_GRID_POINTS      = 2'd0;
    localparam logic [1:0] REG_MAX_SWEEPS       = 2'd1;
    localparam logic [1:0] REG_STEP_SQUARED     = 2'd2;
    localparam logic [1:0] REG_CHANGE_THRESHOLD = 2'd3;

    localparam logic [6:0]  GRID_POINTS_RESET      = 7'd60;
    localparam logic [19:0] MAX_SWEEPS_RESET       = 20'd100000;
    localparam logic [31:0] STEP_SQUARED_RESET     = 32'd1233833;
    localparam logic [62:0] CHANGE_THRESHOLD_RESET = 63'd15;

    localparam logic [62:0] SUM_MAX = {63{1'b1}};

    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    typedef struct packed {
        logic [1:0]   kind;
        logic [11:0]  node_index;
        logic signed [31:0] source_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] node_value;
        logic [19:0]  sweeps_done;
        logic         converged;
        logic [62:0]  change_sum;
    } out_item_t;

    typedef struct packed {
        logic       src_we;
        logic       src_zero;
        logic       sol_we0;
        logic       sol_we1;
        logic       sol_zero;
        logic       rd_bank;
        logic [1:0] acc_op;
        logic       mul_en;
        logic       term_en;
        logic       nv_en;
        logic       sq_en;
        logic       sum_clr;
        logic       sum_en;
        logic       stat_en;
        logic       stat_conv;
        logic       out_load;
        logic       out_read;
        logic       read_zero;
    } dp_cmd_t;

endpackage

/* hw/rtl/jps_ram.sv */
module jps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/jps_datapath.sv */
module jps_datapath #(
    parameter int MAX_GRID   = 64,
    parameter int VALUE_BITS = 32,
    parameter int AW         = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  jps_pkg::dp_cmd_t     cmd,
    input  logic [AW-1:0]        src_waddr,
    input  logic [AW-1:0]        src_raddr,
    input  logic [AW-1:0]        sol_waddr,
    input  logic [AW-1:0]        sol_raddr,
    input  logic [19:0]          sweeps,
    input  logic signed [31:0]   source_value,
    input  logic [31:0]          step_squared,
    input  logic [62:0]          change_threshold,
    output logic                 above_thr,
    output jps_pkg::out_item_t   out_item
);

    localparam int DEPTH = MAX_GRID * MAX_GRID;
    localparam int AC    = ((VALUE_BITS > 33) ? VALUE_BITS : 33) + 3;
    localparam logic signed [AC-1:0] V_HI = AC'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [AC-1:0] V_LO = -V_HI - AC'(1);

    logic [31:0]            src_q;
    logic [VALUE_BITS-1:0]  q0;
    logic [VALUE_BITS-1:0]  q1;
    logic [31:0]            src_wdata;
    logic [VALUE_BITS-1:0]  sol_wdata;
    logic signed [VALUE_BITS-1:0] rd_s;
    logic signed [64:0]     prod_reg;
    logic signed [32:0]     term_reg;
    logic signed [AC-1:0]   acc_reg;
    logic signed [VALUE_BITS-1:0] nv_reg;
    logic signed [VALUE_BITS-1:0] old_reg;
    logic [63:0]            sq_reg;
    logic                   big_reg;
    logic [62:0]            sum_reg;
    logic [19:0]            sweeps_reg;
    logic                   conv_reg;
    logic [62:0]            change_reg;
    logic signed [64:0]     prod_rnd;
    logic signed [AC-1:0]   tot;
    logic signed [AC-1:0]   tot_q;
    logic signed [VALUE_BITS-1:0] nv_sat;
    logic signed [VALUE_BITS:0] diff;
    logic signed [63:0]     diff64;
    logic [63:0]            abs64;
    logic [64:0]            sum_wide;
    logic signed [63:0]     rd64;

    assign src_wdata = cmd.src_zero ? '0 : source_value;
    assign sol_wdata = cmd.sol_zero ? '0 : nv_reg;

    jps_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_src (
        .aclk(aclk), .we(cmd.src_we), .waddr(src_waddr), .wdata(src_wdata),
        .raddr(src_raddr), .rdata(src_q)
    );

    jps_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_bank0 (
        .aclk(aclk), .we(cmd.sol_we0), .waddr(sol_waddr), .wdata(sol_wdata),
        .raddr(sol_raddr), .rdata(q0)
    );

    jps_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_bank1 (
        .aclk(aclk), .we(cmd.sol_we1), .waddr(sol_waddr), .wdata(sol_wdata),
        .raddr(sol_raddr), .rdata(q1)
    );

    assign rd_s     = $signed(cmd.rd_bank ? q1 : q0);
    assign rd64     = 64'(rd_s);
    assign prod_rnd = prod_reg + 65'sd2147483648;
    assign tot      = acc_reg + AC'(term_reg) + AC'(2);
    assign tot_q    = tot >>> 2;
    assign nv_sat   = (tot_q > V_HI) ? VALUE_BITS'(V_HI) :
                      (tot_q < V_LO) ? VALUE_BITS'(V_LO) : VALUE_BITS'(tot_q);
    assign diff     = (VALUE_BITS + 1)'(nv_reg) - (VALUE_BITS + 1)'(old_reg);
    assign diff64   = 64'(diff);
    assign abs64    = diff64[63] ? 64'(-diff64) : 64'(diff64);
    assign sum_wide = {2'b00, sum_reg} + {1'b0, sq_reg};
    assign above_thr = sum_reg > change_threshold;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= $signed(src_q) * $signed({1'b0, step_squared});
        end
        if (cmd.term_en) begin
            term_reg <= 33'(prod_rnd >>> 32);
        end
        case (cmd.acc_op)
            jps_pkg::ACC_LOAD: acc_reg <= AC'(rd_s);
            jps_pkg::ACC_ADD:  acc_reg <= acc_reg + AC'(rd_s);
            default: acc_reg <= acc_reg;
        endcase
        if (cmd.nv_en) begin
            nv_reg  <= nv_sat;
            old_reg <= rd_s;
        end
        if (cmd.sq_en) begin
            sq_reg  <= abs64[31:0] * abs64[31:0];
            big_reg <= |abs64[63:32];
        end
        if (cmd.sum_clr) begin
            sum_reg <= '0;
        end else if (cmd.sum_en) begin
            if (big_reg || sum_wide > {2'b00, jps_pkg::SUM_MAX}) begin
                sum_reg <= jps_pkg::SUM_MAX;
            end else begin
                sum_reg <= sum_wide[62:0];
            end
        end
        if (cmd.out_load) begin
            out_item.node_value  <= (cmd.out_read && !cmd.read_zero) ? rd64[31:0] : '0;
            out_item.sweeps_done <= sweeps_reg;
            out_item.converged   <= conv_reg;
            out_item.change_sum  <= change_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweeps_reg <= '0;
            conv_reg   <= 1'b0;
            change_reg <= '0;
        end else if (cmd.stat_en) begin
            sweeps_reg <= sweeps;
            conv_reg   <= cmd.stat_conv;
            change_reg <= sum_reg;
        end
    end

endmodule

/* hw/rtl/jps_ctrl.sv */
module jps_ctrl #(
    parameter int MAX_GRID = 64,
    parameter int AW       = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_kind,
    input  logic [11:0]      s_idx,
    output logic             m_valid,
    input  logic             m_ready,
    input  logic [6:0]       grid_points,
    input  logic [19:0]      max_sweeps,
    input  logic             above_thr,
    output jps_pkg::dp_cmd_t cmd,
    output logic [AW-1:0]    src_waddr,
    output logic [AW-1:0]    src_raddr,
    output logic [AW-1:0]    sol_waddr,
    output logic [AW-1:0]    sol_raddr,
    output logic [19:0]      sweeps
);

    localparam int DEPTH = MAX_GRID * MAX_GRID;
    localparam int NW    = $clog2(MAX_GRID + 1);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_CLR   = 3'd3;
    localparam logic [2:0] ST_NODE  = 3'd4;
    localparam logic [2:0] ST_SWEEP = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [NW-1:0] n_reg, n_next;
    logic [AW:0]   nsq_reg, nsq_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] j_reg, j_next;
    logic [AW-1:0] rb_reg, rb_next;
    logic [2:0]    ph_reg, ph_next;
    logic [19:0]   p_reg, p_next;
    logic [19:0]   limit_reg, limit_next;
    logic          cur_reg, cur_next;
    logic          solved_reg, solved_next;
    logic [AW:0]   solved_nsq_reg, solved_nsq_next;
    logic          m_valid_reg, m_valid_next;
    logic          rz_reg, rz_next;

    logic [NW-1:0] n_now;
    logic [AW:0]   nsq_now;
    logic [AW-1:0] k;
    logic [AW-1:0] n_ext;
    logic [NW-1:0] last_ij;
    logic [19:0]   p_inc;
    logic          accept;

    assign n_now   = (grid_points < 7'd3) ? NW'(3) :
                     (32'(grid_points) > MAX_GRID) ? NW'(MAX_GRID) : NW'(grid_points);
    assign nsq_now = (AW + 1)'(32'(n_now) * 32'(n_now));
    assign n_ext   = AW'(n_reg);
    assign k       = rb_reg + AW'(j_reg);
    assign last_ij = n_reg - NW'(2);
    assign p_inc   = p_reg + 20'd1;
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign src_raddr = k;
    assign sweeps    = p_inc;

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        n_next          = n_reg;
        nsq_next        = nsq_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        rb_next         = rb_reg;
        ph_next         = ph_reg;
        p_next          = p_reg;
        limit_next      = limit_reg;
        cur_next        = cur_reg;
        solved_next     = solved_reg;
        solved_nsq_next = solved_nsq_reg;
        rz_next         = rz_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd             = '0;
        cmd.rd_bank     = cur_reg;
        cmd.acc_op      = jps_pkg::ACC_HOLD;
        src_waddr       = addr_reg;
        sol_waddr       = addr_reg;
        sol_raddr       = k;

        case (state_reg)
            ST_INIT: begin
                cmd.src_we   = 1'b1;
                cmd.src_zero = 1'b1;
                addr_next    = addr_reg + AW'(1);
                if (32'(addr_reg) == DEPTH - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        jps_pkg::KIND_LOAD: begin
                            cmd.src_we   = 32'(s_idx) < DEPTH;
                            src_waddr    = AW'(s_idx);
                            cmd.out_load = 1'b1;
                            m_valid_next = 1'b1;
                        end
                        jps_pkg::KIND_SOLVE: begin
                            n_next     = n_now;
                            nsq_next   = nsq_now;
                            limit_next = (max_sweeps == 20'd0) ? 20'd1 : max_sweeps;
                            addr_next  = '0;
                            state_next = ST_CLR;
                        end
                        jps_pkg::KIND_READ: begin
                            sol_raddr  = AW'(s_idx);
                            rz_next    = !(solved_reg && 32'(s_idx) < 32'(nsq_now)
                                           && 32'(s_idx) < 32'(solved_nsq_reg));
                            state_next = ST_RD;
                        end
                        default: begin
                            cmd.out_load = 1'b1;
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD: begin
                cmd.out_load  = 1'b1;
                cmd.out_read  = 1'b1;
                cmd.read_zero = rz_reg;
                m_valid_next  = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_CLR: begin
                cmd.sol_we0  = 1'b1;
                cmd.sol_we1  = 1'b1;
                cmd.sol_zero = 1'b1;
                addr_next    = addr_reg + AW'(1);
                if ((AW + 1)'(addr_reg) == nsq_reg - (AW + 1)'(1)) begin
                    cur_next    = 1'b0;
                    p_next      = '0;
                    i_next      = NW'(1);
                    j_next      = NW'(1);
                    rb_next     = n_ext;
                    ph_next     = '0;
                    cmd.sum_clr = 1'b1;
                    state_next  = ST_NODE;
                end
            end
            ST_NODE: begin
                ph_next = ph_reg + 3'd1;
                case (ph_reg)
                    3'd0: sol_raddr = k - n_ext;
                    3'd1: begin
                        sol_raddr   = k + n_ext;
                        cmd.acc_op  = jps_pkg::ACC_LOAD;
                        cmd.mul_en  = 1'b1;
                    end
                    3'd2: begin
                        sol_raddr   = k - AW'(1);
                        cmd.acc_op  = jps_pkg::ACC_ADD;
                        cmd.term_en = 1'b1;
                    end
                    3'd3: begin
                        sol_raddr  = k + AW'(1);
                        cmd.acc_op = jps_pkg::ACC_ADD;
                    end
                    3'd4: begin
                        sol_raddr  = k;
                        cmd.acc_op = jps_pkg::ACC_ADD;
                    end
                    3'd5: cmd.nv_en = 1'b1;
                    3'd6: begin
                        sol_waddr   = k;
                        cmd.sol_we0 = cur_reg;
                        cmd.sol_we1 = !cur_reg;
                        cmd.sq_en   = 1'b1;
                    end
                    default: begin
                        cmd.sum_en = 1'b1;
                        if (j_reg == last_ij) begin
                            j_next = NW'(1);
                            if (i_reg == last_ij) begin
                                state_next = ST_SWEEP;
                            end else begin
                                i_next  = i_reg + NW'(1);
                                rb_next = rb_reg + n_ext;
                            end
                        end else begin
                            j_next = j_reg + NW'(1);
                        end
                    end
                endcase
            end
            ST_SWEEP: begin
                p_next   = p_inc;
                cur_next = !cur_reg;
                if (above_thr && p_inc < limit_reg) begin
                    i_next      = NW'(1);
                    j_next      = NW'(1);
                    rb_next     = n_ext;
                    ph_next     = '0;
                    cmd.sum_clr = 1'b1;
                    state_next  = ST_NODE;
                end else begin
                    cmd.stat_en     = 1'b1;
                    cmd.stat_conv   = !above_thr;
                    solved_next     = 1'b1;
                    solved_nsq_next = nsq_reg;
                    state_next      = ST_OUT;
                end
            end
            ST_OUT: begin
                cmd.out_load = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            addr_reg    <= '0;
            cur_reg     <= 1'b0;
            solved_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            cur_reg     <= cur_next;
            solved_reg  <= solved_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg          <= n_next;
        nsq_reg        <= nsq_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        rb_reg         <= rb_next;
        ph_reg         <= ph_next;
        p_reg          <= p_next;
        limit_reg      <= limit_next;
        solved_nsq_reg <= solved_nsq_next;
        rz_reg         <= rz_next;
    end

endmodule

/* hw/rtl/jacobi_poisson_grid_solver_unit.sv */
// Channel   Ports                                    Payload
// input     s_valid, s_ready, s_data                 kind, node_index, source_value
// result    m_valid, m_ready, m_data                 node_value, sweeps_done, converged,
//                                                    change_sum
// config    cfg_valid, cfg_ready, cfg_index, cfg_data register index and value
//
// A load beat is answered from the idle state; a read beat first waits in a read state for the registered store read.
// A solve first clears the n*n words of both solution banks, then runs its sweeps, one
// interior node at a time through the single read port of each bank, then loads the result.
// After reset the block first clears all MAX_GRID*MAX_GRID words of the source store.
// A new beat is taken while a result waits, as long as the result slot frees that cycle.
module jacobi_poisson_grid_solver_unit #(
    parameter int MAX_GRID   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  jps_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output jps_pkg::out_item_t   m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam int AW = $clog2(MAX_GRID * MAX_GRID);

    logic [6:0]  grid_points_reg;
    logic [19:0] max_sweeps_reg;
    logic [31:0] step_squared_reg;
    logic [62:0] change_threshold_reg;

    jps_pkg::dp_cmd_t cmd;
    logic [AW-1:0] src_waddr;
    logic [AW-1:0] src_raddr;
    logic [AW-1:0] sol_waddr;
    logic [AW-1:0] sol_raddr;
    logic [19:0]   sweeps;
    logic          above_thr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_points_reg      <= jps_pkg::GRID_POINTS_RESET;
            max_sweeps_reg       <= jps_pkg::MAX_SWEEPS_RESET;
            step_squared_reg     <= jps_pkg::STEP_SQUARED_RESET;
            change_threshold_reg <= jps_pkg::CHANGE_THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                jps_pkg::REG_GRID_POINTS:      grid_points_reg      <= cfg_data[6:0];
                jps_pkg::REG_MAX_SWEEPS:       max_sweeps_reg       <= cfg_data[19:0];
                jps_pkg::REG_STEP_SQUARED:     step_squared_reg     <= cfg_data[31:0];
                jps_pkg::REG_CHANGE_THRESHOLD: change_threshold_reg <= cfg_data[62:0];
                default: ;
            endcase
        end
    end

    jps_ctrl #(.MAX_GRID(MAX_GRID), .AW(AW)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(s_data.kind), .s_idx(s_data.node_index),
        .m_valid(m_valid), .m_ready(m_ready),
        .grid_points(grid_points_reg), .max_sweeps(max_sweeps_reg),
        .above_thr(above_thr), .cmd(cmd),
        .src_waddr(src_waddr), .src_raddr(src_raddr),
        .sol_waddr(sol_waddr), .sol_raddr(sol_raddr),
        .sweeps(sweeps)
    );

    jps_datapath #(.MAX_GRID(MAX_GRID), .VALUE_BITS(VALUE_BITS), .AW(AW)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .src_waddr(src_waddr), .src_raddr(src_raddr),
        .sol_waddr(sol_waddr), .sol_raddr(sol_raddr),
        .sweeps(sweeps), .source_value(s_data.source_value),
        .step_squared(step_squared_reg), .change_threshold(change_threshold_reg),
        .above_thr(above_thr), .out_item(m_data)
    );

endmodule

/* hw/rtl/jps_checker.sv */
module jps_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input jps_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input jps_pkg::out_item_t m_data
);

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result beat changed while stalled.");

    a_load_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.kind == jps_pkg::KIND_LOAD
        |=> m_valid && m_data.node_value == 32'sd0)
        else $error("Load beat gave no zero result in the next cycle.");

    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.kind == jps_pkg::KIND_READ |=> !s_ready)
        else $error("Input taken while a read is in flight.");

    a_solve_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.kind == jps_pkg::KIND_SOLVE |=> !s_ready && !m_valid)
        else $error("Solve beat did not hold the block busy.");

endmodule

bind jacobi_poisson_grid_solver_unit jps_checker u_chk (.*);

/* tb/jacobi_poisson_grid_solver_unit_test.sv */
`timescale 1ns / 100ps

module jacobi_poisson_grid_solver_unit_test;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STORE_DEPTH = 4096;
    localparam int IDLE_LIMIT = 400000;
    localparam logic [63:0] MASK63 = 64'h7FFF_FFFF_FFFF_FFFF;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    jps_pkg::in_item_t s_data;
    logic m_valid;
    logic m_ready;
    jps_pkg::out_item_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [63:0] cfg_data;

    jacobi_poisson_grid_solver_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [6:0] grid_reg;
    logic [19:0] sweep_limit_reg;
    logic [31:0] step_sq_reg;
    logic [62:0] threshold_reg;
    longint source_mem [STORE_DEPTH];
    longint solution_mem [STORE_DEPTH];
    logic [19:0] sweeps_seen;
    logic [62:0] change_seen;
    logic converged_seen;

    jps_pkg::out_item_t pending_results [$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit calm = 0;
    bit hold_req = 0;

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic int grid_size();
        int n;
        n = grid_reg;
        if (n < 3) n = 3;
        if (n > 64) n = 64;
        return n;
    endfunction

    task automatic run_solve();
        longint next_sol [STORE_DEPTH];
        int n;
        int k;
        longint limit;
        longint p;
        longint prod;
        longint term;
        longint tot;
        longint nv;
        longint d;
        logic [63:0] ad;
        logic [63:0] sq;
        logic [63:0] sum;
        n = grid_size();
        limit = (sweep_limit_reg == 0) ? 1 : sweep_limit_reg;
        p = 0;
        for (int i = 0; i < STORE_DEPTH; i++) solution_mem[i] = 0;
        do begin
            sum = 0;
            for (int i = 1; i + 1 < n; i++) begin
                for (int j = 1; j + 1 < n; j++) begin
                    k = i * n + j;
                    prod = source_mem[k] * longint'({32'd0, step_sq_reg});
                    term = (prod + 64'sd2147483648) >>> 32;
                    tot = solution_mem[k - n] + solution_mem[k + n]
                        + solution_mem[k - 1] + solution_mem[k + 1] + term;
                    nv = (tot + 2) >>> 2;
                    if (nv > 64'sd2147483647) nv = 64'sd2147483647;
                    if (nv < -64'sd2147483648) nv = -64'sd2147483648;
                    next_sol[k] = nv;
                    d = nv - solution_mem[k];
                    ad = (d < 0) ? -d : d;
                    if (ad >= 64'h1_0000_0000) begin
                        sum = MASK63;
                    end else begin
                        sq = ad * ad;
                        sum = (sq > MASK63 - sum) ? MASK63 : sum + sq;
                    end
                end
            end
            for (int i = 1; i + 1 < n; i++)
                for (int j = 1; j + 1 < n; j++)
                    solution_mem[i * n + j] = next_sol[i * n + j];
            p++;
        end while (sum > {1'b0, threshold_reg} && p < limit);
        sweeps_seen = p[19:0];
        change_seen = sum[62:0];
        converged_seen = (sum <= {1'b0, threshold_reg});
    endtask

    task automatic predict_result(jps_pkg::in_item_t it);
        jps_pkg::out_item_t r;
        int n;
        r = '0;
        case (it.kind)
            jps_pkg::KIND_LOAD: source_mem[it.node_index] = longint'(it.source_value);
            jps_pkg::KIND_SOLVE: run_solve();
            jps_pkg::KIND_READ: begin
                n = grid_size();
                if (it.node_index < n * n) r.node_value = solution_mem[it.node_index][31:0];
            end
            default: ;
        endcase
        r.sweeps_done = sweeps_seen;
        r.converged = converged_seen;
        r.change_sum = change_seen;
        pending_results.push_back(r);
    endtask

    task automatic send_item(logic [1:0] kind, logic [11:0] idx, logic [31:0] value);
        int gap;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data.kind = kind;
        s_data.node_index = idx;
        s_data.source_value = value;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predict_result(s_data);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        case (idx)
            jps_pkg::REG_GRID_POINTS: grid_reg = value[6:0];
            jps_pkg::REG_MAX_SWEEPS: sweep_limit_reg = value[19:0];
            jps_pkg::REG_STEP_SQUARED: step_sq_reg = value[31:0];
            default: threshold_reg = value[62:0];
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(logic [63:0] n, logic [63:0] lim, logic [63:0] st,
                             logic [63:0] thr);
        drain();
        write_reg(jps_pkg::REG_GRID_POINTS, n);
        write_reg(jps_pkg::REG_MAX_SWEEPS, lim);
        write_reg(jps_pkg::REG_STEP_SQUARED, st);
        write_reg(jps_pkg::REG_CHANGE_THRESHOLD, thr);
    endtask

    task automatic test_directed_extremes();
        configure(64'd3, 64'd0, 64'hFFFF_FFFF, 64'd0);
        send_item(jps_pkg::KIND_READ, 12'd4, 32'd0);
        send_item(jps_pkg::KIND_LOAD, 12'd4, 32'h7FFF_FFFF);
        send_item(jps_pkg::KIND_SOLVE, 12'd0, 32'd0);
        send_item(jps_pkg::KIND_READ, 12'd4, 32'd0);
        send_item(jps_pkg::KIND_READ, 12'd9, 32'd0);
        send_item(KIND_UNUSED, 12'hFFF, 32'hFFFF_FFFF);
        send_item(jps_pkg::KIND_LOAD, 12'hFFF, 32'h8000_0000);
        configure(64'd0, 64'hFFFFF, 64'hFFFF_FFFF, 64'd0);
        send_item(jps_pkg::KIND_LOAD, 12'd4, 32'h8000_0000);
        send_item(jps_pkg::KIND_SOLVE, 12'd0, 32'd0);
        send_item(jps_pkg::KIND_READ, 12'd4, 32'd0);
        send_item(jps_pkg::KIND_READ, 12'd0, 32'd0);
        configure(64'd5, 64'd7, 64'd0, {1'b0, {63{1'b1}}});
        send_item(jps_pkg::KIND_LOAD, 12'd6, 32'h0001_0000);
        send_item(jps_pkg::KIND_SOLVE, 12'd0, 32'd0);
        send_item(jps_pkg::KIND_READ, 12'd6, 32'd0);
        configure(64'hFFFF_FFFF_FFFF_FF40, 64'd1, 64'd1233833, 64'd15);
        send_item(jps_pkg::KIND_LOAD, 12'd2000, 32'h7FFF_FFFF);
        send_item(jps_pkg::KIND_SOLVE, 12'd0, 32'd0);
        send_item(jps_pkg::KIND_READ, 12'd2000, 32'd0);
        send_item(jps_pkg::KIND_READ, 12'd4095, 32'd0);
        configure(64'd64, 64'd1, 64'h8000_0000, 64'd15);
        send_item(jps_pkg::KIND_SOLVE, 12'd0, 32'd0);
        send_item(jps_pkg::KIND_READ, 12'd2000, 32'd0);
    endtask

    task automatic random_phase(int count);
        int n;
        int r;
        logic [63:0] thr;
        n = $urandom_range(3, 10);
        case ($urandom_range(0, 3))
            0: thr = 64'd0;
            1: thr = {1'b0, {63{1'b1}}};
            default: thr = {$urandom, $urandom} >> $urandom_range(1, 63);
        endcase
        configure({$urandom, 25'd0, n[6:0]}, {$urandom, 12'd0, 20'($urandom_range(0, 24))},
                  {$urandom, $urandom}, thr);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_item(jps_pkg::KIND_LOAD, ($urandom_range(0, 3) == 0) ? 12'($urandom)
                          : 12'($urandom_range(0, n * n - 1)), $urandom);
            else if (r < 48)
                send_item(jps_pkg::KIND_SOLVE, 12'($urandom), $urandom);
            else if (r < 96)
                send_item(jps_pkg::KIND_READ, ($urandom_range(0, 5) == 0) ? 12'($urandom)
                          : 12'($urandom_range(0, n * n - 1)), $urandom);
            else
                send_item(KIND_UNUSED, 12'($urandom), $urandom);
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) random_phase(160);
    endtask

    task automatic test_backpressure();
        configure(64'd4, 64'd3, 64'h4000_0000, 64'd0);
        send_item(jps_pkg::KIND_LOAD, 12'd5, 32'h0003_0000);
        send_item(jps_pkg::KIND_SOLVE, 12'd0, 32'd0);
        hold_req = 1;
        for (int i = 0; i < 30; i++)
            send_item(jps_pkg::KIND_READ, 12'($urandom_range(0, 15)), 32'd0);
        drain();
        for (int i = 0; i < 10; i++)
            send_item(jps_pkg::KIND_READ, 12'($urandom_range(0, 15)), 32'd0);
    endtask

    task automatic test_steady_stream();
        calm = 1;
        random_phase(80);
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (300) @(negedge aclk);
                hold_req = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", m_data);
            end else begin
                if (m_data.node_value !== pending_results[0].node_value
                    || m_data.sweeps_done !== pending_results[0].sweeps_done
                    || m_data.converged !== pending_results[0].converged
                    || m_data.change_sum !== pending_results[0].change_sum) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, actual %p",
                                 pending_results[0], m_data);
                end
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = jps_pkg::REG_GRID_POINTS;
        cfg_data = '0;
        grid_reg = jps_pkg::GRID_POINTS_RESET;
        sweep_limit_reg = jps_pkg::MAX_SWEEPS_RESET;
        step_sq_reg = jps_pkg::STEP_SQUARED_RESET;
        threshold_reg = jps_pkg::CHANGE_THRESHOLD_RESET;
        sweeps_seen = 0;
        change_seen = 0;
        converged_seen = 0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            source_mem[i] = 0;
            solution_mem[i] = 0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed_extremes();
        test_backpressure();
        test_random();
        test_steady_stream();
        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
